// ----- rtl/core/tks_pkg.sv -----
package tks_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int SCORE_BITS_DEF = 32;
  localparam int ID_BITS_DEF    = 16;

  localparam int            KEEP_W     = 7;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT_OUT
  } cell_op_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } sel_state_t;

endpackage

// ----- rtl/core/top_k_score_selector.sv -----
// insertion: one item per cycle while in_stall is low, into a sorted chain of
// CAPACITY cells; all cells compare the new item at once and shift together
// after an item flagged last, the chain drains from its head: one result per
// cycle while out_stall is low, keep_count results at most; input is stalled
// until the drain ends; the first result shows in the cycle after the last item
// reset (synchronous, active low) empties the chain and sets keep_count to 64
module top_k_score_selector import tks_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SCORE_BITS-1:0] in_score,
  input  logic [ID_BITS-1:0]    in_item_id,
  input  logic                  in_last_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SCORE_BITS-1:0] out_ranked_score,
  output logic [ID_BITS-1:0]    out_ranked_id,
  output logic                  out_last_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [KEEP_W-1:0]     cfg_keep_count
);

  sel_state_t        state_r, state_nxt;
  logic [KEEP_W-1:0] keep_count_r, keep_count_nxt;
  cell_op_t          op;

  logic [SCORE_BITS-1:0] c_score [CAPACITY+1];
  logic [ID_BITS-1:0]    c_id    [CAPACITY+1];
  logic                  c_valid [CAPACITY+1];
  logic                  c_above [CAPACITY];

  assign cfg_ready = 1'b1;

  always_comb begin
    keep_count_nxt = keep_count_r;
    if (cfg_valid) begin
      keep_count_nxt = cfg_keep_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
      state_r      <= ST_COLLECT;
    end else begin
      keep_count_r <= keep_count_nxt;
      state_r      <= state_nxt;
    end
  end

  // tail of the chain reads as empty
  assign c_score[CAPACITY] = '0;
  assign c_id[CAPACITY]    = '0;
  assign c_valid[CAPACITY] = 1'b0;

  always_comb begin
    state_nxt    = state_r;
    op           = OP_HOLD;
    in_stall     = 1'b0;
    out_valid    = 1'b0;
    out_last_out = !c_valid[1];
    case (state_r)
      ST_COLLECT: begin
        if (in_valid) begin
          op = OP_INSERT;
          if (in_last_item) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = c_valid[0];
        if (!c_valid[0]) begin
          state_nxt = ST_COLLECT;
        end else if (!out_stall) begin
          op = OP_SHIFT_OUT;
          if (out_last_out) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  assign out_ranked_score = c_score[0];
  assign out_ranked_id    = c_id[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SCORE_BITS-1:0] p_score;
    logic [ID_BITS-1:0]    p_id;
    logic                  p_valid;
    logic                  p_above;
    logic                  keep_en;

    assign keep_en = KEEP_W'(i) < keep_count_r;

    if (i == 0) begin : g_head
      assign p_score = '0;
      assign p_id    = '0;
      assign p_valid = 1'b0;
      assign p_above = 1'b0;
    end else begin : g_body
      assign p_score = c_score[i-1];
      assign p_id    = c_id[i-1];
      assign p_valid = c_valid[i-1];
      assign p_above = c_above[i-1];
    end

    tks_cell #(
      .SCORE_BITS (SCORE_BITS),
      .ID_BITS    (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .keep_en    (keep_en),
      .new_score  (in_score),
      .new_id     (in_item_id),
      .prev_score (p_score),
      .prev_id    (p_id),
      .prev_valid (p_valid),
      .prev_above (p_above),
      .next_score (c_score[i+1]),
      .next_id    (c_id[i+1]),
      .next_valid (c_valid[i+1]),
      .score      (c_score[i]),
      .id         (c_id[i]),
      .valid      (c_valid[i]),
      .above      (c_above[i])
    );
  end

endmodule

// ----- rtl/core/tks_cell.sv -----
module tks_cell import tks_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_op_t              op,
  input  logic                  keep_en,
  input  logic [SCORE_BITS-1:0] new_score,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic [SCORE_BITS-1:0] prev_score,
  input  logic [ID_BITS-1:0]    prev_id,
  input  logic                  prev_valid,
  input  logic                  prev_above,
  input  logic [SCORE_BITS-1:0] next_score,
  input  logic [ID_BITS-1:0]    next_id,
  input  logic                  next_valid,
  output logic [SCORE_BITS-1:0] score,
  output logic [ID_BITS-1:0]    id,
  output logic                  valid,
  output logic                  above
);

  logic [SCORE_BITS-1:0] score_r, score_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic                  valid_r, valid_nxt;

  // new item ranks above this cell's entry, or the cell is empty
  assign above = !valid_r || (new_score > score_r) ||
                 ((new_score == score_r) && (new_id < id_r));

  always_comb begin
    score_nxt = score_r;
    id_nxt    = id_r;
    valid_nxt = valid_r;
    case (op)
      OP_INSERT: begin
        if (prev_above) begin
          score_nxt = prev_score;
          id_nxt    = prev_id;
          valid_nxt = prev_valid;
        end else if (above) begin
          score_nxt = new_score;
          id_nxt    = new_id;
          valid_nxt = 1'b1;
        end
        valid_nxt = valid_nxt && keep_en;
      end
      OP_SHIFT_OUT: begin
        score_nxt = next_score;
        id_nxt    = next_id;
        valid_nxt = next_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    id_r    <= id_nxt;
  end

  assign score = score_r;
  assign id    = id_r;
  assign valid = valid_r;

endmodule

// ----- test/top_k_score_selector_test.sv -----
`timescale 1ns / 100ps

module top_k_score_selector_test;
  import tks_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int LONG_HOLD = 200;

  typedef logic [SCORE_BITS_DEF-1:0] score_t;
  typedef logic [ID_BITS_DEF-1:0]    id_t;
  typedef struct packed {
    score_t score;
    id_t    id;
    logic   last;
  } ranked_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  score_t            in_score       = '0;
  id_t               in_item_id     = '0;
  logic              in_last_item   = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  score_t            out_ranked_score;
  id_t               out_ranked_id;
  logic              out_last_out;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [KEEP_W-1:0] cfg_keep_count = '0;

  top_k_score_selector u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_score         (in_score),
    .in_item_id       (in_item_id),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ranked_score (out_ranked_score),
    .out_ranked_id    (out_ranked_id),
    .out_last_out     (out_last_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_keep_count   (cfg_keep_count)
  );

  always #6 clk = ~clk;

  score_t            chain_score [CAP];
  id_t               chain_id    [CAP];
  int                chain_len      = 0;
  logic [KEEP_W-1:0] keep_now       = KEEP_RESET;
  ranked_t           ranked_due [$];
  ranked_t           ranked_head;
  int                mismatch_count = 0;
  int                items_sent     = 0;
  int                results_seen   = 0;
  int                sets_done      = 0;
  bit                tx_jitter      = 1'b0;
  bit                rx_jitter      = 1'b0;
  int                hold_asked     = 0;
  int                hold_taken     = 0;
  int                hold_left      = 0;
  int                rx_wait        = 0;
  int                rx_gap;

  function automatic bit outranks(score_t sa, id_t ia, score_t sb, id_t ib);
    if (sa != sb) begin
      return sa > sb;
    end
    return ia < ib;
  endfunction

  function automatic void rank_item(score_t s, id_t id, logic last);
    int eff;
    int pos;
    int top;
    int i;
    eff = (keep_now > CAP) ? CAP : keep_now;
    pos = 0;
    while (pos < chain_len && !outranks(s, id, chain_score[pos], chain_id[pos])) begin
      pos++;
    end
    if (pos < CAP) begin
      top = (chain_len < CAP) ? chain_len : CAP - 1;
      for (i = top; i > pos; i--) begin
        chain_score[i] = chain_score[i-1];
        chain_id[i]    = chain_id[i-1];
      end
      chain_score[pos] = s;
      chain_id[pos]    = id;
      if (chain_len < CAP) begin
        chain_len++;
      end
    end
    if (chain_len > eff) begin
      chain_len = eff;
    end
    if (last) begin
      for (i = 0; i < chain_len; i++) begin
        ranked_due.push_back('{score: chain_score[i], id: chain_id[i],
                               last: (i == chain_len - 1)});
      end
      chain_len = 0;
    end
  endfunction

  function automatic score_t draw_score();
    case ($urandom_range(0, 3))
      0:       return score_t'($urandom_range(0, 7));
      1:       return {{(SCORE_BITS_DEF-3){1'b1}}, 3'($urandom_range(0, 7))};
      default: return score_t'($urandom());
    endcase
  endfunction

  function automatic id_t draw_id();
    if ($urandom_range(0, 3) == 0) begin
      return id_t'($urandom_range(0, 3));
    end
    return id_t'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(input score_t s, input id_t id, input logic last);
    int gap;
    gap = tx_jitter ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_score     <= s;
    in_item_id   <= id;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rank_item(s, id, last);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ranked_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] k);
    settle();
    cfg_valid      <= 1'b1;
    cfg_keep_count <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    keep_now = k;
  endtask

  // long receiver hold, counted here
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_left  <= LONG_HOLD;
      hold_taken <= hold_asked;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else if (rx_jitter && out_valid && !out_stall) begin
      rx_gap = $urandom_range(0, 6);
      out_stall <= (rx_gap != 0);
      rx_wait   <= (rx_gap != 0) ? rx_gap - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (ranked_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing due, id %0h score %0h",
                                  out_ranked_id, out_ranked_score));
      end else begin
        ranked_head = ranked_due.pop_front();
        if (out_ranked_score !== ranked_head.score) begin
          report_mismatch($sformatf("score %0h, wanted %0h",
                                    out_ranked_score, ranked_head.score));
        end
        if (out_ranked_id !== ranked_head.id) begin
          report_mismatch($sformatf("id %0h, wanted %0h", out_ranked_id, ranked_head.id));
        end
        if (out_last_out !== ranked_head.last) begin
          report_mismatch($sformatf("last flag %b, wanted %b",
                                    out_last_out, ranked_head.last));
        end
      end
    end
  end

  task automatic test_directed();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    // extremes, ties and identical items
    send_item('0, '0, 1'b0);
    send_item('1, '1, 1'b0);
    send_item('1, '0, 1'b0);
    send_item(32'h8000_0000, 16'h0005, 1'b0);
    send_item(32'h8000_0000, 16'h0005, 1'b0);
    send_item(32'h8000_0000, 16'h0003, 1'b0);
    send_item(32'h0000_0001, '1, 1'b1);
    write_keep(7'd1);
    send_item(32'd5, 16'd1, 1'b0);
    send_item(32'd9, 16'd2, 1'b0);
    send_item(32'd9, 16'd1, 1'b1);
    // nothing kept, empty output
    write_keep(7'd0);
    send_item(32'd7, 16'd7, 1'b0);
    send_item(32'd8, 16'd8, 1'b1);
    // saturating keep
    write_keep(7'd65);
    send_item(32'd3, 16'd3, 1'b1);
    // keep lowered part way through a set
    write_keep(7'd64);
    send_item(32'd10, 16'd1, 1'b0);
    send_item(32'd20, 16'd2, 1'b0);
    send_item(32'd30, 16'd3, 1'b0);
    send_item(32'd40, 16'd4, 1'b0);
    write_keep(7'd2);
    send_item(32'd5, 16'd5, 1'b0);
    send_item(32'd50, 16'd6, 1'b1);
  endtask

  task automatic test_random_sets(input int item_goal);
    int                len;
    int                cut;
    int                big_left;
    int                n;
    logic [KEEP_W-1:0] k;
    big_left = 2;
    while (items_sent < item_goal) begin
      tx_jitter = ($urandom_range(0, 3) != 0);
      rx_jitter = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       k = 7'd1;
        1:       k = 7'(CAP);
        2:       k = 7'd127;
        3:       k = 7'($urandom_range(65, 126));
        4:       k = 7'd0;
        default: k = 7'($urandom_range(2, 16));
      endcase
      // overfill the chain a couple of times
      if (big_left > 0) begin
        len = $urandom_range(CAP + 1, CAP + 8);
        k   = (big_left == 2) ? 7'd127 : 7'(CAP);
        big_left--;
      end else begin
        len = $urandom_range(1, 12);
      end
      cut = (len > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : 0;
      write_keep(k);
      for (n = 0; n < len; n++) begin
        if (cut != 0 && n == cut) begin
          write_keep(7'($urandom_range(0, 20)));
        end
        send_item(draw_score(), draw_id(), n == len - 1);
      end
      sets_done++;
    end
  endtask

  task automatic test_backpressure();
    int n;
    write_keep(7'(CAP));
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    hold_asked <= hold_asked + 1;
    for (n = 0; n < 12; n++) begin
      send_item(draw_score(), draw_id(), n == 11);
    end
    for (n = 0; n < 6; n++) begin
      send_item(draw_score(), draw_id(), n == 5);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sets(items_sent + 245);
    test_backpressure();
    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d items in %0d random sets, %0d ranked results checked",
             items_sent, sets_done, results_seen);
    $display("keep counts 0 to 127, chain overflow, ties, mid-set keep changes, long hold");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results still due", ranked_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
